>>> rtl/bbc_pkg.sv
// bbc_pkg: bracket kind codes and character decode for the bracket checker
// standalone package, no dependencies
package bbc_pkg;

  // bracket kinds as kept on the stack
  typedef enum logic [1:0] {
    KIND_ROUND  = 2'd0,
    KIND_SQUARE = 2'd1,
    KIND_CURLY  = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  // ascii codes of the six brackets
  localparam logic [7:0] CH_OPEN_ROUND   = 8'h28;
  localparam logic [7:0] CH_CLOSE_ROUND  = 8'h29;
  localparam logic [7:0] CH_OPEN_SQUARE  = 8'h5B;
  localparam logic [7:0] CH_CLOSE_SQUARE = 8'h5D;
  localparam logic [7:0] CH_OPEN_CURLY   = 8'h7B;
  localparam logic [7:0] CH_CLOSE_CURLY  = 8'h7D;

  // kind of an opening bracket, none for anything else
  function automatic kind_t open_kind(input logic [7:0] c);
    kind_t k;
    case (c)
      CH_OPEN_ROUND:  k = KIND_ROUND;
      CH_OPEN_SQUARE: k = KIND_SQUARE;
      CH_OPEN_CURLY:  k = KIND_CURLY;
      default:        k = KIND_NONE;
    endcase
    return k;
  endfunction

  // kind of a closing bracket, none for anything else
  function automatic kind_t close_kind(input logic [7:0] c);
    kind_t k;
    case (c)
      CH_CLOSE_ROUND:  k = KIND_ROUND;
      CH_CLOSE_SQUARE: k = KIND_SQUARE;
      CH_CLOSE_CURLY:  k = KIND_CURLY;
      default:         k = KIND_NONE;
    endcase
    return k;
  endfunction

endpackage

>>> rtl/bracket_balance_checker_top.sv
// a verdict is registered and valid in the cycle after the last byte of a string is accepted
// throughput: one byte per cycle, but a last byte stalls while a stalled verdict is held; the stack
// top sits in a register and the single memory read port always prefetches the entry just below it
// reset (rst, synchronous): clears stack level, failure and overflow flags and the
// output valid; the stack memory itself is not cleared
// depends on bbc_pkg
module bracket_balance_checker_top #(
  parameter int STACK_DEPTH = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] char_code,
  input  logic       is_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       balanced,
  output logic       overflowed
);
  import bbc_pkg::*;

  localparam int LW = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(STACK_DEPTH);

  // stack memory, holds every entry below the level including the top
  kind_t   stack_mem [STACK_DEPTH];
  kind_t   below_kind;
  logic [AW-1:0] rd_addr;

  logic [LW-1:0] level, level_next;
  kind_t   top_kind, top_kind_next;
  logic    failed, failed_next;
  logic    ovf, ovf_next;
  logic    push;
  logic    accept;
  logic    res_balanced, res_ovf;
  logic [LW-1:0] rd_level;
  kind_t   ok, ck;

  // a last byte needs the output slot; other bytes always go in
  assign in_stall = out_valid & out_stall & is_last;
  assign accept   = in_valid & ~in_stall;

  assign ok = open_kind(char_code);
  assign ck = close_kind(char_code);

  // stack update for one transaction
  always_comb begin
    level_next    = level;
    top_kind_next = top_kind;
    failed_next   = failed;
    ovf_next      = ovf;
    push          = 1'b0;
    if (accept && !failed) begin
      if (ok != KIND_NONE) begin
        if (level == LW'(STACK_DEPTH)) begin
          ovf_next = 1'b1;
        end else begin
          push          = 1'b1;
          level_next    = level + LW'(1);
          top_kind_next = ok;
        end
      end else if (level == '0) begin
        failed_next = 1'b1;
      end else if (ck != KIND_NONE) begin
        level_next    = level - LW'(1);
        top_kind_next = below_kind;
        if (top_kind != ck) begin
          failed_next = 1'b1;
        end
      end
    end
    res_balanced = ~failed_next & ~ovf_next & (level_next == '0);
    res_ovf      = ovf_next;
    if (accept && is_last) begin
      level_next  = '0;
      failed_next = 1'b0;
      ovf_next    = 1'b0;
    end
  end

  // prefetch the entry below the next top
  assign rd_level = level_next - LW'(2);
  assign rd_addr  = rd_level[AW-1:0];

  // memory write and registered read
  always_ff @(posedge clk) begin
    if (push) begin
      stack_mem[level[AW-1:0]] <= ok;
    end
    below_kind <= stack_mem[rd_addr];
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      level  <= '0;
      failed <= 1'b0;
      ovf    <= 1'b0;
    end else begin
      level  <= level_next;
      failed <= failed_next;
      ovf    <= ovf_next;
    end
  end

  // top of stack register
  always_ff @(posedge clk) begin
    top_kind <= top_kind_next;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && is_last) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && is_last) begin
      balanced   <= res_balanced;
      overflowed <= res_ovf;
    end
  end

endmodule

>>> rtl/bbc_checker.sv
// bbc_checker: port-level assertions for the bracket checker, bound to the top level
// depends on bbc_pkg and bracket_balance_checker_top
module bbc_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic [7:0] char_code,
  input logic       is_last,
  input logic       out_valid,
  input logic       out_stall,
  input logic       balanced,
  input logic       overflowed
);
  import bbc_pkg::*;

  logic last_accept;
  logic last_is_open;

  assign last_accept  = in_valid & ~in_stall & is_last;
  assign last_is_open = (char_code == CH_OPEN_ROUND) || (char_code == CH_OPEN_SQUARE) ||
                        (char_code == CH_OPEN_CURLY);

  // a stalled verdict holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(balanced) && $stable(overflowed))
    else $error("stalled verdict changed");

  // every last byte gives a verdict in the next cycle
  a_last_verdict: assert property (@(posedge clk) disable iff (rst)
    last_accept |=> out_valid)
    else $error("no verdict after last byte");

  // a string that ends on an opening bracket is never balanced
  a_open_end: assert property (@(posedge clk) disable iff (rst)
    last_accept && last_is_open |=> out_valid && !balanced)
    else $error("string ending in opening bracket reported balanced");

  // overflow always means unbalanced
  a_ovf_fail: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(balanced && overflowed))
    else $error("balanced and overflowed together");

  // with an empty output slot the input never stalls
  a_no_stall: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output slot");

endmodule

bind bracket_balance_checker_top bbc_checker u_bbc_checker (.*);

>>> bench/testbench.sv
// testbench for bracket_balance_checker_top: directed, stack depth, backpressure and random strings
// predicts each verdict from accepted bytes and checks results in order
// depends on bbc_pkg and rtl/bracket_balance_checker_top.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import bbc_pkg::*;

  localparam int STACK_DEPTH = 64;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_LIMIT = 2000;

  typedef logic [7:0] byte_t;

  typedef struct {
    logic balanced;
    logic overflowed;
  } verdict_t;

  logic       clk;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  byte_t      char_code = '0;
  logic       is_last = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       balanced;
  logic       overflowed;

  // predictor state
  kind_t       kind_mem [STACK_DEPTH];
  int unsigned nest_level = 0;
  bit          string_failed = 1'b0;
  bit          string_overflow = 1'b0;
  verdict_t    verdict_q[$];

  int errors = 0;
  int items_sent = 0;

  // sender and receiver idling controls
  bit idle_on = 1'b0;
  int burst_left = 0;
  bit stall_on = 1'b0;
  int hold_asks = 0;
  int hold_taken = 0;
  int hold_left = 0;
  bit stall_level = 1'b0;
  int run_left = 0;

  bracket_balance_checker_top #(.STACK_DEPTH(STACK_DEPTH)) dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .char_code  (char_code),
    .is_last    (is_last),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .balanced   (balanced),
    .overflowed (overflowed)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // bracket decode: sets is_open / is_close and the kind
  function automatic kind_t bracket_kind(input byte_t c, output bit is_open,
                                         output bit is_close);
    kind_t k;
    is_open = 1'b1;
    is_close = 1'b0;
    k = KIND_NONE;
    case (c)
      CH_OPEN_ROUND:   k = KIND_ROUND;
      CH_OPEN_SQUARE:  k = KIND_SQUARE;
      CH_OPEN_CURLY:   k = KIND_CURLY;
      CH_CLOSE_ROUND: begin
        is_open = 1'b0; is_close = 1'b1; k = KIND_ROUND;
      end
      CH_CLOSE_SQUARE: begin
        is_open = 1'b0; is_close = 1'b1; k = KIND_SQUARE;
      end
      CH_CLOSE_CURLY: begin
        is_open = 1'b0; is_close = 1'b1; k = KIND_CURLY;
      end
      default: is_open = 1'b0;
    endcase
    return k;
  endfunction

  function automatic byte_t opener_char(input kind_t k);
    case (k)
      KIND_SQUARE: return CH_OPEN_SQUARE;
      KIND_CURLY:  return CH_OPEN_CURLY;
      default:     return CH_OPEN_ROUND;
    endcase
  endfunction

  function automatic byte_t closer_char(input kind_t k);
    case (k)
      KIND_SQUARE: return CH_CLOSE_SQUARE;
      KIND_CURLY:  return CH_CLOSE_CURLY;
      default:     return CH_CLOSE_ROUND;
    endcase
  endfunction

  // random byte that is none of the six brackets
  function automatic byte_t filler_byte();
    byte_t c;
    bit    op, cl;
    do begin
      c = byte_t'($urandom_range(0, 255));
      void'(bracket_kind(c, op, cl));
    end while (op || cl);
    return c;
  endfunction

  // advance the bracket stack by one byte, queue a verdict on the last one
  function automatic void track_byte(input byte_t c, input logic last);
    kind_t    k;
    bit       op, cl;
    verdict_t v;
    k = bracket_kind(c, op, cl);
    if (!string_failed) begin
      if (op) begin
        if (nest_level >= STACK_DEPTH) string_overflow = 1'b1;
        else begin
          kind_mem[nest_level] = k;
          nest_level++;
        end
      end else if (nest_level == 0) begin
        string_failed = 1'b1;
      end else if (cl) begin
        nest_level--;
        if (kind_mem[nest_level] != k) string_failed = 1'b1;
      end
    end
    if (last) begin
      v.balanced = !string_failed && !string_overflow && nest_level == 0;
      v.overflowed = string_overflow;
      verdict_q.push_back(v);
      nest_level = 0;
      string_failed = 1'b0;
      string_overflow = 1'b0;
    end
  endfunction

  // compare each verdict with the oldest expected one, then track accepted bytes
  always @(posedge clk) begin
    verdict_t v;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (verdict_q.size() == 0) begin
          $display("%0t unexpected verdict: balanced %0b overflowed %0b",
                   $time, balanced, overflowed);
          errors++;
        end else begin
          v = verdict_q.pop_front();
          if (balanced !== v.balanced) begin
            $display("%0t balanced mismatch: expected %0b actual %0b",
                     $time, v.balanced, balanced);
            errors++;
          end
          if (overflowed !== v.overflowed) begin
            $display("%0t overflowed mismatch: expected %0b actual %0b",
                     $time, v.overflowed, overflowed);
            errors++;
          end
        end
      end
      if (in_valid && !in_stall) track_byte(char_code, is_last);
    end
  end

  // receiver stall: long hold-off on request, else random runs of stall and flow
  always @(posedge clk) begin
    if (hold_asks != hold_taken) begin
      hold_taken = hold_asks;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (!stall_on) begin
      out_stall <= 1'b0;
    end else begin
      if (run_left == 0) begin
        stall_level = !stall_level;
        run_left = stall_level ? $urandom_range(1, 8) : $urandom_range(1, 12);
      end
      run_left--;
      out_stall <= stall_level;
    end
  end

  // offer one byte and wait for the transaction, with burst gaps when idling
  task automatic send_byte(input byte_t c, input logic last);
    int gap;
    if (idle_on) begin
      if (burst_left == 0) begin
        gap = $urandom_range(0, 6);
        burst_left = $urandom_range(1, 20);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      burst_left--;
    end
    in_valid <= 1'b1;
    char_code <= c;
    is_last <= last;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  task automatic send_string(input byte_t s[$]);
    foreach (s[i]) send_byte(s[i], i == s.size() - 1);
  endtask

  // mostly well-formed strings with random content, some broken or pure noise
  task automatic make_random_string(output byte_t s[$]);
    kind_t open_q[$];
    kind_t k;
    int    style, pairs, opened, pos;
    bit    nested;
    s = {};
    style = $urandom_range(0, 99);
    if (style < 10) begin
      repeat ($urandom_range(1, 8)) s.push_back(byte_t'($urandom_range(0, 255)));
      return;
    end
    nested = style < 14;
    pairs = nested ? $urandom_range(60, 70) : $urandom_range(1, 8);
    opened = 0;
    while (opened < pairs || open_q.size() > 0) begin
      if (opened < pairs && (nested || open_q.size() == 0 || $urandom_range(0, 2) != 0)) begin
        k = kind_t'($urandom_range(0, 2));
        open_q.push_back(k);
        s.push_back(opener_char(k));
        opened++;
      end else if ($urandom_range(0, 4) == 0) begin
        s.push_back(filler_byte());
      end else begin
        s.push_back(closer_char(open_q.pop_back()));
      end
    end
    // break about a quarter of the well-formed strings
    if ($urandom_range(0, 3) == 0) begin
      case ($urandom_range(0, 3))
        0: begin
          pos = $urandom_range(0, s.size() - 1);
          s[pos] = byte_t'($urandom_range(0, 255));
        end
        1: begin
          void'(s.pop_back());
          if (s.size() == 0) s.push_back(byte_t'($urandom_range(0, 255)));
        end
        2: s.push_back(closer_char(kind_t'($urandom_range(0, 2))));
        default: s.push_front(filler_byte());
      endcase
    end
  endtask

  // extremes of the byte, each bracket pair, mismatch, empty-stack close,
  // ignored bytes inside brackets and bytes after a failure
  task automatic test_directed_cases();
    idle_on = 1'b0;
    stall_on <= 1'b0;
    send_string('{8'h00});
    send_string('{8'hFF});
    send_string('{CH_OPEN_ROUND, CH_CLOSE_ROUND});
    send_string('{CH_OPEN_SQUARE, CH_CLOSE_SQUARE});
    send_string('{CH_OPEN_CURLY, CH_CLOSE_CURLY});
    send_string('{CH_OPEN_ROUND, CH_CLOSE_SQUARE});
    send_string('{CH_CLOSE_ROUND});
    send_string('{CH_OPEN_CURLY});
    send_string('{CH_OPEN_SQUARE, 8'h00, CH_CLOSE_SQUARE});
    send_string('{CH_CLOSE_SQUARE, CH_OPEN_ROUND, CH_CLOSE_ROUND});
    send_string('{CH_OPEN_ROUND, CH_OPEN_CURLY, CH_CLOSE_ROUND, CH_CLOSE_CURLY});
  endtask

  // fill the stack exactly, then push past it, then overflow on the last byte
  task automatic test_stack_depth();
    byte_t s[$];
    kind_t k[$];
    idle_on = 1'b1;
    stall_on <= 1'b1;
    for (int n = STACK_DEPTH; n <= STACK_DEPTH + 1; n++) begin
      s = {};
      k = {};
      repeat (n) begin
        k.push_back(kind_t'($urandom_range(0, 2)));
        s.push_back(opener_char(k[$]));
      end
      while (k.size() > 0) s.push_back(closer_char(k.pop_back()));
      send_string(s);
    end
    s = {};
    repeat (STACK_DEPTH + 1) s.push_back(opener_char(kind_t'($urandom_range(0, 2))));
    send_string(s);
  endtask

  // receiver holds off while short strings keep coming, so the block backs up
  task automatic test_output_backpressure();
    byte_t s[$];
    idle_on = 1'b0;
    stall_on <= 1'b0;
    hold_asks <= hold_asks + 1;
    repeat (150) begin
      s = {};
      if ($urandom_range(0, 1)) s = '{CH_OPEN_ROUND, CH_CLOSE_ROUND};
      else s.push_back(byte_t'($urandom_range(0, 255)));
      send_string(s);
    end
  endtask

  // random strings, switching idling on and off every few dozen strings
  task automatic test_random_strings(input int n_items);
    byte_t s[$];
    int    start, strings;
    start = items_sent;
    strings = 0;
    while (items_sent - start < n_items) begin
      if (strings % 40 == 0) begin
        idle_on = $urandom_range(0, 3) != 0;
        stall_on <= $urandom_range(0, 3) != 0;
      end
      make_random_string(s);
      send_string(s);
      strings++;
    end
  endtask

  initial begin
    int waited;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_cases();
    test_stack_depth();
    test_output_backpressure();
    test_random_strings(1230);
    in_valid <= 1'b0;
    is_last <= 1'b0;
    // drain the outstanding verdicts
    waited = 0;
    while (verdict_q.size() > 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);
    if (verdict_q.size() != 0) begin
      $display("%0t %0d verdicts never arrived", $time, verdict_q.size());
      errors++;
    end
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // run limit
  initial begin
    #3_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
